FILE: sv/cds_pkg.sv
// Shared types, opcodes and calendar helpers for the calendar date stepper.
// No dependencies; used by cds_ctrl, cds_datapath and calendar_date_stepper_top.
package cds_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [4:0]  DEF_DAY   = 5'd1;
  localparam logic [3:0]  DEF_MONTH = 4'd1;
  localparam logic [13:0] DEF_YEAR  = 14'd2023;

  localparam logic [3:0] LAST_MONTH = 4'd12;

  // Reciprocal of 400 scaled by 2**23; exact quotient for any 14-bit year.
  localparam logic [14:0] RECIP_400 = 15'd20972;
  localparam int          RECIP_SHIFT = 23;
  localparam logic [8:0]  CENT_1 = 9'd100;
  localparam logic [8:0]  CENT_2 = 9'd200;
  localparam logic [8:0]  CENT_3 = 9'd300;

  typedef struct packed {
    logic capture;
    logic leap_q;
    logic leap_r;
    logic load_commit;
    logic step;
    logic clamp;
    logic out_load;
  } cds_cmd_t;

  typedef struct packed {
    logic is_add;
    logic mag_zero;
    logic at_bound;
    logic yr_cross;
    logic out_free;
  } cds_stat_t;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd2: n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

FILE: sv/calendar_date_stepper_top.sv
// Calendar date stepper: loads a Gregorian date or moves it by a signed day count.
// A load runs the leap-year calculation and a range check before the result is registered;
// an add steps a day at a time (|day_delta| unless a bound stops it) and redoes the leap-year
// calculation per year boundary crossed. Items are taken one at a time, only while idle.
// Reset (rst, synchronous, active high) sets the date to 1/1/2023 and empties the output.
// Depends on cds_pkg, cds_ctrl and cds_datapath.
module calendar_date_stepper_top
  import cds_pkg::*;
#(
  parameter int YEAR_LIMIT = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // load_day, load_month, load_year, day_delta, zero fill
  input  logic        s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // cur_day, cur_month, cur_year, load_rejected,
                                // range_clamped, zero fill
);

  cds_cmd_t  cmd;
  cds_stat_t stat;

  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic        out_rejected;
  logic        out_clamped;

  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cds_datapath #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (s_tuser),
    .in_day       (s_tdata[4:0]),
    .in_month     (s_tdata[8:5]),
    .in_year      (s_tdata[22:9]),
    .in_delta     (s_tdata[38:23]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_day      (out_day),
    .out_month    (out_month),
    .out_year     (out_year),
    .out_rejected (out_rejected),
    .out_clamped  (out_clamped)
  );

  assign m_tdata = {7'd0, out_clamped, out_rejected, out_year, out_month, out_day};

`ifndef ASSERT_OFF
  a_step_needs_days: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !stat.mag_zero)
    else $error("day step issued with no days left");

  a_result_follows_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result register not valid after load");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new beat accepted while an item is in progress");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_rejected && out_clamped))
    else $error("rejected and clamped flags both set");
`endif

endmodule

FILE: sv/cds_ctrl.sv
// Controller state machine of the calendar date stepper.
// Depends on cds_pkg for the command and status structs.
module cds_ctrl
  import cds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cds_stat_t stat,
  output cds_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LQ   = 3'd1;
  localparam logic [2:0] S_LR   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_LQ;
        end
      end
      S_LQ: begin
        cmd.leap_q = 1'b1;
        state_next = S_LR;
      end
      S_LR: begin
        cmd.leap_r = 1'b1;
        state_next = stat.is_add ? S_STEP : S_CHK;
      end
      S_CHK: begin
        cmd.load_commit = 1'b1;
        state_next = S_FIN;
      end
      S_STEP: begin
        if (stat.mag_zero) begin
          state_next = S_FIN;
        end else if (stat.at_bound) begin
          cmd.clamp = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.step = 1'b1;
          state_next = stat.yr_cross ? S_LQ : S_STEP;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/cds_datapath.sv
// Datapath of the calendar date stepper: date registers, leap-year unit,
// day stepper and output register. Depends on cds_pkg.
module cds_datapath
  import cds_pkg::*;
#(
  parameter int YEAR_LIMIT = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  cds_cmd_t    cmd,
  output cds_stat_t   stat,
  input  logic        in_op,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [13:0] in_year,
  input  logic [15:0] in_delta,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic        out_rejected,
  output logic        out_clamped
);

  localparam logic [13:0] YL = 14'(YEAR_LIMIT);

  logic [4:0]  day_reg;
  logic [3:0]  month_reg;
  logic [13:0] year_reg;
  logic        op;
  logic [4:0]  ld_day;
  logic [3:0]  ld_month;
  logic [13:0] ld_year;
  logic        neg;
  logic [15:0] mag;
  logic [5:0]  quot;
  logic        leap;
  logic        rejected;
  logic        clamped;

  logic [13:0] yr_src;
  logic [28:0] prod;
  logic [13:0] rem_full;
  logic [8:0]  rem400;
  logic        leap_next;
  logic [4:0]  dim;
  logic [4:0]  dim_prev;
  logic [3:0]  prev_month;
  logic        fw_day;
  logic        fw_mon;
  logic        bk_day;
  logic        bk_mon;
  logic        load_ok;

  assign yr_src   = (op == OP_ADD) ? year_reg : ld_year;
  assign prod     = 29'(yr_src) * 29'(RECIP_400);
  assign rem_full = yr_src - 14'(quot) * 14'd400;
  assign rem400   = rem_full[8:0];
  assign leap_next = (rem400[1:0] == 2'd0) && (rem400 != CENT_1) &&
                     (rem400 != CENT_2) && (rem400 != CENT_3);

  assign dim        = days_in(month_reg, leap);
  assign prev_month = month_reg - 4'd1;
  assign dim_prev   = days_in(prev_month, leap);
  assign fw_day     = day_reg < dim;
  assign fw_mon     = month_reg < LAST_MONTH;
  assign bk_day     = day_reg > 5'd1;
  assign bk_mon     = month_reg > 4'd1;

  assign load_ok = (ld_month >= 4'd1) && (ld_month <= LAST_MONTH) && (ld_year >= 14'd1) &&
                   (ld_year <= YL) && (ld_day >= 5'd1) && (ld_day <= days_in(ld_month, leap));

  assign stat.is_add   = (op == OP_ADD);
  assign stat.mag_zero = (mag == 16'd0);
  assign stat.yr_cross = neg ? (!bk_day && !bk_mon) : (!fw_day && !fw_mon);
  assign stat.at_bound = neg ? (!bk_day && !bk_mon && (year_reg <= 14'd1))
                             : (!fw_day && !fw_mon && (year_reg >= YL));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= DEF_DAY;
      month_reg <= DEF_MONTH;
      year_reg  <= DEF_YEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_commit) begin
        if (load_ok) begin
          day_reg   <= ld_day;
          month_reg <= ld_month;
          year_reg  <= ld_year;
        end else begin
          day_reg   <= DEF_DAY;
          month_reg <= DEF_MONTH;
          year_reg  <= DEF_YEAR;
        end
      end else if (cmd.step) begin
        if (neg) begin
          if (bk_day) begin
            day_reg <= day_reg - 5'd1;
          end else if (bk_mon) begin
            month_reg <= prev_month;
            day_reg   <= dim_prev;
          end else begin
            year_reg  <= year_reg - 14'd1;
            month_reg <= LAST_MONTH;
            day_reg   <= 5'd31;
          end
        end else begin
          if (fw_day) begin
            day_reg <= day_reg + 5'd1;
          end else if (fw_mon) begin
            month_reg <= month_reg + 4'd1;
            day_reg   <= 5'd1;
          end else begin
            year_reg  <= year_reg + 14'd1;
            month_reg <= 4'd1;
            day_reg   <= 5'd1;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= in_op;
      ld_day   <= in_day;
      ld_month <= in_month;
      ld_year  <= in_year;
      neg      <= in_delta[15] && (in_op == OP_ADD);
      mag      <= (in_op == OP_ADD) ? (in_delta[15] ? (16'd0 - in_delta) : in_delta) : 16'd0;
      rejected <= 1'b0;
      clamped  <= 1'b0;
    end else begin
      if (cmd.step) begin
        mag <= mag - 16'd1;
      end
      if (cmd.clamp) begin
        clamped <= 1'b1;
      end
      if (cmd.load_commit) begin
        rejected <= !load_ok;
      end
    end
    if (cmd.leap_q) begin
      quot <= prod[RECIP_SHIFT +: 6];
    end
    if (cmd.leap_r) begin
      leap <= leap_next;
    end
    if (cmd.out_load) begin
      out_day      <= day_reg;
      out_month    <= month_reg;
      out_year     <= year_reg;
      out_rejected <= rejected;
      out_clamped  <= clamped;
    end
  end

endmodule
